// ===== design/nta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and constants of the neighbor table aging unit.
// ----------------------------------------------------------------------------
package nta_pkg;

	localparam int ADDR_W          = 8;
	localparam int CNT_W           = 5;
	localparam int ENT_W           = ADDR_W + CNT_W;
	localparam int OUT_CNT_W       = 5;
	localparam int AGE_W           = 4;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic [CNT_W-1:0] CNT_MAX         = 5'd31;
	localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 4'd3;

	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_BEACON = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_AGE_LIMIT = 1'b0;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} nta_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} nta_status_t;

endpackage

// ===== design/nta_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nta_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module nta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/nta_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nta_ctrl
// Sequencer: takes one word, runs the table walk, then posts the result.
// ----------------------------------------------------------------------------
module nta_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  nta_pkg::nta_status_t st,
	output nta_pkg::nta_cmd_t    cmd
);
	import nta_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/nta_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nta_dp
// Table datapath: walk counters, address match, aging and compaction,
// insert, and the result register.
// ----------------------------------------------------------------------------
module nta_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nta_pkg::nta_cmd_t                 cmd,
	output nta_pkg::nta_status_t              st,
	input  logic                              action,
	input  logic [nta_pkg::ADDR_W-1:0]        neighbor_address,
	input  logic [nta_pkg::AGE_W-1:0]         age_limit,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [nta_pkg::OUT_CNT_W-1:0]     entry_count,
	output logic                              was_present,
	output logic                              was_inserted,
	output logic                              dropped_full,
	output logic [nta_pkg::OUT_CNT_W-1:0]     removed_count
);
	import nta_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic              action_q;
	logic [ADDR_W-1:0] naddr_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_q;
	logic [CW-1:0]     wr_q;
	logic              found_q;
	logic              valid_s1;
	logic [AW-1:0]     rd_s1;

	logic              issue;
	logic [ENT_W-1:0]  rdata;
	logic [ADDR_W-1:0] ent_addr;
	logic [CNT_W-1:0]  ent_cnt;
	logic [CNT_W-1:0]  cnt_inc;
	logic              proc;
	logic              hit;
	logic              keep;
	logic              insert;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [ENT_W-1:0]  wdata;
	logic [CW-1:0]     count_next;

	assign issue    = cmd.scan && !found_q && (rd_q != count_q);
	assign ent_addr = rdata[ENT_W-1:CNT_W];
	assign ent_cnt  = rdata[CNT_W-1:0];
	assign cnt_inc  = (ent_cnt == CNT_MAX) ? CNT_MAX : ent_cnt + CNT_W'(1);
	assign proc     = valid_s1 && !found_q;
	assign hit      = proc && (action_q == ACT_BEACON) && (ent_addr == naddr_q);
	assign keep     = proc && (action_q == ACT_TICK) && (ent_cnt <= {1'b0, age_limit});
	assign insert   = cmd.finish && (action_q == ACT_BEACON) && !found_q
	                  && (count_q < DEPTH_C);

	always_comb begin
		we    = 1'b0;
		waddr = rd_s1;
		wdata = {ent_addr, CNT_W'(0)};
		if (hit) begin
			we = 1'b1;
		end else if (keep) begin
			we    = 1'b1;
			waddr = wr_q[AW-1:0];
			wdata = {ent_addr, cnt_inc};
		end else if (insert) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = {naddr_q, CNT_W'(0)};
		end
	end

	always_comb begin
		if (action_q == ACT_TICK) begin
			count_next = wr_q;
		end else if (insert) begin
			count_next = count_q + CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	nta_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (rdata)
	);

	assign st.scan_done = found_q || ((rd_q == count_q) && !valid_s1);
	assign st.out_free  = !out_valid || !out_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			found_q   <= 1'b0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (cmd.load) begin
				rd_q    <= '0;
				wr_q    <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					rd_q <= rd_q + CW'(1);
				end
				if (keep) begin
					wr_q <= wr_q + CW'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_q   <= count_next;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rd_s1 <= rd_q[AW-1:0];
		if (cmd.load) begin
			action_q <= action;
			naddr_q  <= neighbor_address;
		end
		if (cmd.finish) begin
			entry_count   <= OUT_CNT_W'(count_next);
			was_present   <= (action_q == ACT_BEACON) && found_q;
			was_inserted  <= insert;
			dropped_full  <= (action_q == ACT_BEACON) && !found_q && !(count_q < DEPTH_C);
			removed_count <= (action_q == ACT_TICK) ? OUT_CNT_W'(count_q - wr_q)
			                                        : OUT_CNT_W'(0);
		end
	end

endmodule

// ===== design/neighbor_table_aging_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_aging_unit
// Packed neighbor table with per-entry miss counters, beacon refresh/insert
// and tick-driven aging with in-order compaction.
// ----------------------------------------------------------------------------
// One word is worked on at a time. The table memory is walked one entry
// per cycle through its single read port, whose read data is registered;
// the end of the walk is then seen and the result is posted. A beacon
// that hits stops the walk early, and an empty table gives its result
// without walking.
// The next word can be accepted the cycle after the result is posted. The
// result sits in an output register, and a new word is taken while it waits;
// a walk that ends while an older result is still unread holds until that
// result is taken. age_limit lives at byte address 0 of the register port.
module neighbor_table_aging_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [nta_pkg::ADDR_W-1:0]        neighbor_address,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [nta_pkg::OUT_CNT_W-1:0]     entry_count,
	output logic                              was_present,
	output logic                              was_inserted,
	output logic                              dropped_full,
	output logic [nta_pkg::OUT_CNT_W-1:0]     removed_count,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nta_pkg::PADDR_W-1:0]       paddr,
	input  logic [nta_pkg::PDATA_W-1:0]       pwdata,
	output logic [nta_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);
	import nta_pkg::*;

	nta_cmd_t         cmd;
	nta_status_t      st;
	logic [AGE_W-1:0] age_limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_AGE_LIMIT)) begin
			age_limit_q <= pwdata[AGE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_AGE_LIMIT) ? {{(PDATA_W-AGE_W){1'b0}}, age_limit_q}
	                                             : '0;

	nta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	nta_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.action           (action),
		.neighbor_address (neighbor_address),
		.age_limit        (age_limit_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.entry_count      (entry_count),
		.was_present      (was_present),
		.was_inserted     (was_inserted),
		.dropped_full     (dropped_full),
		.removed_count    (removed_count)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while walk not started");

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free)
		else $error("result register overwritten");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones({was_present, was_inserted, dropped_full}) <= 1))
		else $error("beacon outcome flags overlap");

	a_tick_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (removed_count != '0)) |-> !(was_present || was_inserted || dropped_full))
		else $error("beacon flag on aging word");

	a_insert_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_inserted) |-> (entry_count != '0))
		else $error("insert left table empty");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_aging_unit testbench
// Sends beacon and tick words with random gaps while the result side stalls
// at random. A table tracker in the bench follows every accepted word and
// queues the result it must produce; each result word is checked field by
// field against the oldest queued one. The age limit is changed over the
// APB port between traffic phases, only while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
	import nta_pkg::*;

	localparam int DEPTH      = 16;
	localparam int SETTLE     = DEPTH + 8;
	localparam int STALL_MAX  = 17;
	localparam int IDLE_LIMIT = 3000;

	localparam logic [PADDR_W-1:0] AGE_LIMIT_ADDR = 3'd0;
	localparam logic [PADDR_W-1:0] SPARE_ADDR     = 3'd4;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] entry_count;
		logic                 was_present;
		logic                 was_inserted;
		logic                 dropped_full;
		logic [OUT_CNT_W-1:0] removed_count;
	} table_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 action;
	logic [ADDR_W-1:0]    neighbor_address;
	logic                 out_valid;
	logic                 out_stall;
	logic [OUT_CNT_W-1:0] entry_count;
	logic                 was_present;
	logic                 was_inserted;
	logic                 dropped_full;
	logic [OUT_CNT_W-1:0] removed_count;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// tracked table contents
	logic [ADDR_W-1:0] known_addr [DEPTH];
	logic [CNT_W-1:0]  known_miss [DEPTH];
	int                known_held;
	logic [AGE_W-1:0]  known_age_limit;

	table_result_t pending_results[$];
	int            error_count;
	int            idle_cycles = 0;
	int            sent_words;
	int            taken_results = 0;
	bit            send_calm;
	bit            take_calm = 1'b0;

	neighbor_table_aging_unit #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.neighbor_address(neighbor_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entry_count(entry_count),
		.was_present(was_present),
		.was_inserted(was_inserted),
		.dropped_full(dropped_full),
		.removed_count(removed_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait(bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, STALL_MAX);
	endfunction

	function automatic table_result_t apply_word(logic act, logic [ADDR_W-1:0] a);
		table_result_t    r;
		int               wr;
		int               i;
		bit               hit;
		logic [CNT_W-1:0] prior_miss;
		r = '0;
		if (act == ACT_TICK) begin
			wr = 0;
			for (i = 0; i < known_held; i++) begin
				prior_miss = known_miss[i];
				if (prior_miss <= {1'b0, known_age_limit}) begin
					known_addr[wr] = known_addr[i];
					known_miss[wr] = (prior_miss < CNT_MAX) ? prior_miss + 1'b1 : CNT_MAX;
					wr++;
				end
			end
			r.removed_count = OUT_CNT_W'(known_held - wr);
			known_held = wr;
		end else begin
			hit = 1'b0;
			for (i = 0; i < known_held; i++) begin
				if (!hit && known_addr[i] == a) begin
					known_miss[i] = '0;
					hit = 1'b1;
				end
			end
			if (hit) begin
				r.was_present = 1'b1;
			end else if (known_held < DEPTH) begin
				known_addr[known_held] = a;
				known_miss[known_held] = '0;
				known_held++;
				r.was_inserted = 1'b1;
			end else begin
				r.dropped_full = 1'b1;
			end
		end
		r.entry_count = OUT_CNT_W'(known_held);
		return r;
	endfunction

	// called right after a falling edge, returns right after one
	task automatic send_word(input logic act, input logic [ADDR_W-1:0] a);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		neighbor_address = a;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_word(act, a));
		@(negedge clk);
		sent_words++;
		if (sent_words % 40 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic settle_unit();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (a[2] == REG_AGE_LIMIT)
			known_age_limit = d[AGE_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_age_limit();
		logic [PDATA_W-1:0] d;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = AGE_LIMIT_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (d !== {{(PDATA_W-AGE_W){1'b0}}, known_age_limit}) begin
			$error("age_limit: expected %0d, actual %0d", known_age_limit, d);
			error_count++;
		end
	endtask

	task automatic set_age_limit(input logic [AGE_W-1:0] limit);
		settle_unit();
		apb_write(AGE_LIMIT_ADDR, {(PDATA_W-AGE_W)'($urandom), limit});
		check_age_limit();
	endtask

	task automatic test_reset_value();
		check_age_limit();
	endtask

	task automatic test_directed_table_ops();
		int i;
		send_word(ACT_TICK, 8'hA5);
		send_word(ACT_BEACON, 8'h00);
		send_word(ACT_BEACON, 8'hFF);
		send_word(ACT_BEACON, 8'h00);
		for (i = 1; i <= 14; i++)
			send_word(ACT_BEACON, ADDR_W'(i));
		send_word(ACT_BEACON, 8'h80);
		send_word(ACT_BEACON, 8'hFF);
		send_word(ACT_TICK, 8'h5A);
		send_word(ACT_BEACON, 8'h05);
		set_age_limit(4'd0);
		// all but the refreshed entry go, then that one too
		send_word(ACT_TICK, 8'h00);
		send_word(ACT_TICK, 8'hFF);
	endtask

	task automatic test_spare_register();
		settle_unit();
		apb_write(SPARE_ADDR, $urandom);
		check_age_limit();
	endtask

	task automatic test_aging_traffic(input logic [AGE_W-1:0] limit, input int words,
			input int tick_pct, input int pool_size, input bit pause_midway);
		logic [ADDR_W-1:0] pool [40];
		int                i;
		for (i = 0; i < 40; i++)
			pool[i] = ADDR_W'($urandom_range(0, 255));
		set_age_limit(limit);
		for (i = 0; i < words; i++) begin
			if (pause_midway && i == words / 2)
				settle_unit();
			if ($urandom_range(0, 99) < tick_pct)
				send_word(ACT_TICK, ADDR_W'($urandom_range(0, 255)));
			else if ($urandom_range(0, 4) == 0)
				send_word(ACT_BEACON, ADDR_W'($urandom_range(0, 255)));
			else
				send_word(ACT_BEACON, pool[$urandom_range(0, pool_size - 1)]);
		end
	endtask

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// result side
	initial begin
		table_result_t exp_r;
		int            gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = draw_wait(take_calm);
			if (gap > 0) begin
				out_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			taken_results++;
			if (taken_results % 40 == 0)
				take_calm = ($urandom_range(0, 3) == 0);
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending");
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("entry_count", exp_r.entry_count, entry_count);
				check_field("was_present", exp_r.was_present, was_present);
				check_field("was_inserted", exp_r.was_inserted, was_inserted);
				check_field("dropped_full", exp_r.dropped_full, dropped_full);
				check_field("removed_count", exp_r.removed_count, removed_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("neighbor_table_aging_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_TICK;
		neighbor_address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		known_held = 0;
		known_age_limit = AGE_LIMIT_RESET;
		error_count = 0;
		sent_words = 0;
		send_calm = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_value();
		test_directed_table_ops();
		test_spare_register();
		test_aging_traffic(4'd15, 325, 30, 24, 1'b0);
		test_aging_traffic(4'd0, 325, 5, 40, 1'b1);
		test_aging_traffic(AGE_LIMIT_RESET, 325, 15, 32, 1'b0);
		test_aging_traffic(4'd7, 325, 20, 20, 1'b0);
		test_aging_traffic(AGE_W'($urandom_range(0, 15)), 325, 12, 36, 1'b0);

		settle_unit();
		if (error_count == 0 && pending_results.size() == 0)
			$display("neighbor_table_aging_unit regression: pass");
		else
			$display("neighbor_table_aging_unit regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
design/nta_pkg.sv
design/nta_ram.sv
design/nta_ctrl.sv
design/nta_dp.sv
design/neighbor_table_aging_unit.sv
tb/testbench.sv
